### hdl/go_back_n_link_controller_macros.svh
// Assertion macros shared by the link controller RTL.
// Each check is clocked on the given clock and held off while reset is low.
`ifndef GO_BACK_N_LINK_CONTROLLER_MACROS_SVH
`define GO_BACK_N_LINK_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication check.
`define GBN_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbn: same-cycle check failed");

// Next-cycle implication check.
`define GBN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbn: next-cycle check failed");

`else

`define GBN_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define GBN_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/gbn_pkg.sv
package gbn_pkg;

    // Default geometry of the link controller.
    localparam int SEQ_BITS_DEF     = 3;
    localparam int PACKET_WIDTH_DEF = 32;

    // Retransmit timer register.
    localparam int                 TIMER_W     = 16;
    localparam logic [TIMER_W-1:0] RETX_RESET  = 16'd2000;

    // Request selector on the input stream.
    localparam int ACT_W = 2;
    localparam logic [ACT_W-1:0] ACT_NEW_PACKET = 2'd0;
    localparam logic [ACT_W-1:0] ACT_PHY_READY  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FRAME_RX   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_TIMEOUT    = 2'd3;

    // Received frame type.
    localparam logic RX_KIND_DATA = 1'b0;
    localparam logic RX_KIND_ACK  = 1'b1;

    // Result kind on the output stream.
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_SEND_DATA  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SEND_ACK   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DELIVER    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STOP_TIMER = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STATUS     = 3'd4;

endpackage

### hdl/gbn_slot_ram.sv
module gbn_slot_ram #(
    parameter int ADDR_W = 3,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    // One write port, one registered read port; read data holds when not read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/go_back_n_link_controller.sv
// Go-Back-N link controller: one request in, one to nine results out.
// Requests are decoded into state registers; results are registered at the output.
// One result per cycle while the output is ready; new requests wait until all are out.
// A timeout streams the window out of the slot RAM, one read per result.
// Reset (i_rst_n low, synchronous) empties the window and clears the sequence state;
// slot RAM contents are not cleared, only slots inside the window are read.
`include "go_back_n_link_controller_macros.svh"

module go_back_n_link_controller #(
    parameter int SEQ_BITS     = gbn_pkg::SEQ_BITS_DEF,
    parameter int PACKET_WIDTH = gbn_pkg::PACKET_WIDTH_DEF,
    localparam int IN_BITS  = 2 * PACKET_WIDTH + 2 * SEQ_BITS + 1,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 2 * SEQ_BITS + PACKET_WIDTH + gbn_pkg::TIMER_W + 1,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration: retransmit timer length.
    input  logic                        i_cfg_we,
    input  logic [gbn_pkg::TIMER_W-1:0] i_cfg_wdata,
    // Request stream.
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // tdata from bit 0: tx_packet, rx_valid, rx_seq, rx_ack, rx_packet, zero fill
    input  logic [IN_W-1:0]             i_s_axis_tdata,
    // tuser from bit 0: action (2 bits), rx_kind
    input  logic [gbn_pkg::ACT_W:0]     i_s_axis_tuser,
    // Result stream.
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // tdata from bit 0: seq, ack_number, packet, timer_length, network_enable, zero fill
    output logic [OUT_W-1:0]            o_m_axis_tdata,
    // tuser from bit 0: kind
    output logic [gbn_pkg::KIND_W-1:0]  o_m_axis_tuser,
    output logic                        o_m_axis_tlast
);

    import gbn_pkg::*;

    localparam logic [SEQ_BITS-1:0] WINDOW  = {SEQ_BITS{1'b1}};
    localparam logic [SEQ_BITS-1:0] SEQ_ONE = SEQ_BITS'(1);
    localparam logic [SEQ_BITS-1:0] SEQ_TWO = SEQ_BITS'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEND,
        S_STATUS,
        S_DELIVER,
        S_ACK,
        S_STOP,
        S_RESEND
    } t_state;

    // Request fields.
    logic [ACT_W-1:0]        in_action;
    logic                    in_rx_kind;
    logic [PACKET_WIDTH-1:0] in_tx_packet;
    logic                    in_rx_valid;
    logic [SEQ_BITS-1:0]     in_rx_seq;
    logic [SEQ_BITS-1:0]     in_rx_ack;
    logic [PACKET_WIDTH-1:0] in_rx_packet;

    assign in_action    = i_s_axis_tuser[ACT_W-1:0];
    assign in_rx_kind   = i_s_axis_tuser[ACT_W];
    assign in_tx_packet = i_s_axis_tdata[PACKET_WIDTH-1:0];
    assign in_rx_valid  = i_s_axis_tdata[PACKET_WIDTH];
    assign in_rx_seq    = i_s_axis_tdata[PACKET_WIDTH+SEQ_BITS:PACKET_WIDTH+1];
    assign in_rx_ack    = i_s_axis_tdata[PACKET_WIDTH+2*SEQ_BITS:PACKET_WIDTH+SEQ_BITS+1];
    assign in_rx_packet = i_s_axis_tdata[2*PACKET_WIDTH+2*SEQ_BITS:PACKET_WIDTH+2*SEQ_BITS+1];

    // Link state and sequencer registers.
    t_state                  r_state, n_state;
    logic [SEQ_BITS-1:0]     r_base, n_base;
    logic [SEQ_BITS-1:0]     r_next, n_next;
    logic [SEQ_BITS-1:0]     r_outstanding, n_outstanding;
    logic [SEQ_BITS-1:0]     r_expected, n_expected;
    logic                    r_phy, n_phy;
    logic [SEQ_BITS-1:0]     r_cnt, n_cnt;
    logic [SEQ_BITS-1:0]     r_seq, n_seq;
    logic [PACKET_WIDTH-1:0] r_pkt, n_pkt;
    logic                    r_en, n_en;
    logic [TIMER_W-1:0]      r_retx;

    // Output register.
    logic                    r_out_valid, n_out_valid;
    logic [KIND_W-1:0]       r_o_kind, n_o_kind;
    logic [SEQ_BITS-1:0]     r_o_seq, n_o_seq;
    logic [SEQ_BITS-1:0]     r_o_ack, n_o_ack;
    logic [PACKET_WIDTH-1:0] r_o_pkt, n_o_pkt;
    logic [TIMER_W-1:0]      r_o_timer, n_o_timer;
    logic                    r_o_en, n_o_en;
    logic                    r_o_last, n_o_last;

    // Slot RAM ports.
    logic                    ram_we;
    logic [SEQ_BITS-1:0]     ram_waddr;
    logic [PACKET_WIDTH-1:0] ram_wdata;
    logic                    ram_re;
    logic [SEQ_BITS-1:0]     ram_raddr;
    logic [PACKET_WIDTH-1:0] ram_rdata;

    logic                    can_load;
    logic                    s_accept;
    logic [SEQ_BITS-1:0]     ack_ofs;
    logic                    ack_hit;
    logic [SEQ_BITS-1:0]     cur_ack;
    logic                    loop_busy;

    gbn_slot_ram #(
        .ADDR_W (SEQ_BITS),
        .DATA_W (PACKET_WIDTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign can_load  = !r_out_valid || i_m_axis_tready;
    assign s_accept  = i_s_axis_tvalid && (r_state == S_IDLE);
    assign cur_ack   = r_expected - SEQ_ONE;
    assign loop_busy = (r_state == S_RESEND) || (r_state == S_STOP);

    // A cumulative ack releases frames base..rx_ack when rx_ack lies inside the window.
    assign ack_ofs = in_rx_ack - r_base;
    assign ack_hit = ack_ofs < r_outstanding;

    // Sequencer: decodes a request, updates the link state and emits its results.
    always_comb begin
        n_state       = r_state;
        n_base        = r_base;
        n_next        = r_next;
        n_outstanding = r_outstanding;
        n_expected    = r_expected;
        n_phy         = r_phy;
        n_cnt         = r_cnt;
        n_seq         = r_seq;
        n_pkt         = r_pkt;
        n_en          = r_en;

        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_o_kind    = r_o_kind;
        n_o_seq     = r_o_seq;
        n_o_ack     = r_o_ack;
        n_o_pkt     = r_o_pkt;
        n_o_timer   = r_o_timer;
        n_o_en      = r_o_en;
        n_o_last    = r_o_last;

        ram_we    = 1'b0;
        ram_waddr = r_next;
        ram_wdata = in_tx_packet;
        ram_re    = 1'b0;
        ram_raddr = r_seq + SEQ_ONE;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_STATUS;
                    case (in_action)
                        ACT_NEW_PACKET: begin
                            if (r_outstanding != WINDOW) begin
                                ram_we        = 1'b1;
                                n_outstanding = r_outstanding + SEQ_ONE;
                                n_next        = r_next + SEQ_ONE;
                                n_phy         = 1'b0;
                                n_seq         = r_next;
                                n_pkt         = in_tx_packet;
                                n_state       = S_SEND;
                            end
                        end
                        ACT_PHY_READY: begin
                            n_phy = 1'b1;
                        end
                        ACT_FRAME_RX: begin
                            if (in_rx_valid) begin
                                n_seq = r_base;
                                n_cnt = '0;
                                if (ack_hit) begin
                                    n_cnt         = ack_ofs + SEQ_ONE;
                                    n_base        = in_rx_ack + SEQ_ONE;
                                    n_outstanding = r_outstanding - (ack_ofs + SEQ_ONE);
                                    n_state       = S_STOP;
                                end
                                if (in_rx_kind == RX_KIND_DATA) begin
                                    n_phy   = 1'b0;
                                    n_state = S_ACK;
                                    if (in_rx_seq == r_expected) begin
                                        n_expected = r_expected + SEQ_ONE;
                                        n_pkt      = in_rx_packet;
                                        n_state    = S_DELIVER;
                                    end
                                end
                            end
                        end
                        ACT_TIMEOUT: begin
                            if (r_outstanding != '0) begin
                                ram_re    = 1'b1;
                                ram_raddr = r_base;
                                n_seq     = r_base;
                                n_cnt     = r_outstanding;
                                n_phy     = 1'b0;
                                n_state   = S_RESEND;
                            end
                        end
                        default: begin
                            n_state = S_STATUS;
                        end
                    endcase
                    n_en = (n_outstanding != WINDOW) && n_phy;
                end
            end

            S_SEND: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_o_kind    = KIND_SEND_DATA;
                    n_o_seq     = r_seq;
                    n_o_ack     = cur_ack;
                    n_o_pkt     = r_pkt;
                    n_o_timer   = r_retx;
                    n_o_en      = r_en;
                    n_o_last    = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            S_STATUS: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_o_kind    = KIND_STATUS;
                    n_o_seq     = '0;
                    n_o_ack     = cur_ack;
                    n_o_pkt     = '0;
                    n_o_timer   = '0;
                    n_o_en      = r_en;
                    n_o_last    = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            // The expected sequence has already moved on; delivery reports the old ack.
            S_DELIVER: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_o_kind    = KIND_DELIVER;
                    n_o_seq     = '0;
                    n_o_ack     = r_expected - SEQ_TWO;
                    n_o_pkt     = r_pkt;
                    n_o_timer   = '0;
                    n_o_en      = r_en;
                    n_o_last    = 1'b0;
                    n_state     = S_ACK;
                end
            end

            S_ACK: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_o_kind    = KIND_SEND_ACK;
                    n_o_seq     = '0;
                    n_o_ack     = cur_ack;
                    n_o_pkt     = '0;
                    n_o_timer   = '0;
                    n_o_en      = r_en;
                    n_o_last    = (r_cnt == '0);
                    n_state     = (r_cnt == '0) ? S_IDLE : S_STOP;
                end
            end

            S_STOP: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_o_kind    = KIND_STOP_TIMER;
                    n_o_seq     = r_seq;
                    n_o_ack     = cur_ack;
                    n_o_pkt     = '0;
                    n_o_timer   = '0;
                    n_o_en      = r_en;
                    n_o_last    = (r_cnt == SEQ_ONE);
                    n_seq       = r_seq + SEQ_ONE;
                    n_cnt       = r_cnt - SEQ_ONE;
                    if (r_cnt == SEQ_ONE) begin
                        n_state = S_IDLE;
                    end
                end
            end

            // Slot data for r_seq is read and held; fetch the next slot as it goes out.
            S_RESEND: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_o_kind    = KIND_SEND_DATA;
                    n_o_seq     = r_seq;
                    n_o_ack     = cur_ack;
                    n_o_pkt     = ram_rdata;
                    n_o_timer   = r_retx;
                    n_o_en      = r_en;
                    n_o_last    = (r_cnt == SEQ_ONE);
                    n_seq       = r_seq + SEQ_ONE;
                    n_cnt       = r_cnt - SEQ_ONE;
                    if (r_cnt == SEQ_ONE) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_re = 1'b1;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        r_seq     <= n_seq;
        r_pkt     <= n_pkt;
        r_en      <= n_en;
        r_o_kind  <= n_o_kind;
        r_o_seq   <= n_o_seq;
        r_o_ack   <= n_o_ack;
        r_o_pkt   <= n_o_pkt;
        r_o_timer <= n_o_timer;
        r_o_en    <= n_o_en;
        r_o_last  <= n_o_last;
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_base        <= '0;
            r_next        <= '0;
            r_outstanding <= '0;
            r_expected    <= '0;
            r_phy         <= 1'b0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_base        <= n_base;
            r_next        <= n_next;
            r_outstanding <= n_outstanding;
            r_expected    <= n_expected;
            r_phy         <= n_phy;
            r_cnt         <= n_cnt;
            r_out_valid   <= n_out_valid;
        end
    end

    // Retransmit timer register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retx <= RETX_RESET;
        end else if (i_cfg_we) begin
            r_retx <= i_cfg_wdata;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_o_kind;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tdata  = OUT_W'({r_o_en, r_o_timer, r_o_pkt, r_o_ack, r_o_seq});

    // The window edges and the outstanding count always agree.
    `GBN_ASSERT_IMPLY(a_window_edges, i_clk, i_rst_n, 1'b1, (r_base + r_outstanding) == r_next)
    // The slot RAM is never written and read in the same cycle.
    `GBN_ASSERT_IMPLY(a_slot_port, i_clk, i_rst_n, ram_we, !ram_re)
    // Loops over the window never run with an empty count.
    `GBN_ASSERT_IMPLY(a_loop_count, i_clk, i_rst_n, loop_busy, r_cnt != '0)
    // An accepted request always leaves idle, so it produces at least one result.
    `GBN_ASSERT_NEXT(a_request_taken, i_clk, i_rst_n, s_accept, r_state != S_IDLE)

endmodule

### sim/tb_go_back_n_link_controller.sv
`timescale 1ns / 100ps

module tb_go_back_n_link_controller;

    import gbn_pkg::*;

    localparam int SEQ_W        = 3;
    localparam int PKT_W        = 32;
    localparam int IN_W         = 72;
    localparam int OUT_W        = 56;
    localparam logic [SEQ_W-1:0] SEND_WINDOW = 3'd7;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ITEMS = 380;
    localparam int PHASES       = 4;
    localparam int CYCLE_LIMIT  = 600000;

    // One request on the input stream.
    typedef struct {
        logic [ACT_W-1:0] action;
        logic [PKT_W-1:0] tx_packet;
        logic             rx_valid;
        logic             rx_kind;
        logic [SEQ_W-1:0] rx_seq;
        logic [SEQ_W-1:0] rx_ack;
        logic [PKT_W-1:0] rx_packet;
    } t_link_req;

    // One result on the output stream.
    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [SEQ_W-1:0]   seq;
        logic [SEQ_W-1:0]   ack_number;
        logic [PKT_W-1:0]   packet;
        logic [TIMER_W-1:0] timer_length;
        logic               network_enable;
        logic               last;
    } t_link_result;

    // A directed request, optionally with its single result written out by hand.
    typedef struct {
        t_link_req    req;
        bit           typed;
        t_link_result result;
    } t_directed_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [TIMER_W-1:0] i_cfg_wdata = '0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    // tdata from bit 0: tx_packet, rx_valid, rx_seq, rx_ack, rx_packet, zero fill
    logic [IN_W-1:0]    i_s_axis_tdata = '0;
    // tuser from bit 0: action (2 bits), rx_kind
    logic [ACT_W:0]     i_s_axis_tuser = '0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    // tdata from bit 0: seq, ack_number, packet, timer_length, network_enable, zero fill
    logic [OUT_W-1:0]   o_m_axis_tdata;
    // tuser from bit 0: kind
    logic [KIND_W-1:0]  o_m_axis_tuser;
    logic               o_m_axis_tlast;

    // Mirror of the link state, advanced on every accepted request.
    logic [SEQ_W-1:0]   link_base = '0;
    logic [SEQ_W-1:0]   link_next_seq = '0;
    logic [SEQ_W-1:0]   link_in_flight = '0;
    logic [SEQ_W-1:0]   link_rx_expect = '0;
    logic               link_phy_ready = 1'b0;
    logic [PKT_W-1:0]   link_slots [0:(1<<SEQ_W)-1];
    logic [TIMER_W-1:0] link_retx_time = RETX_RESET;

    t_link_result  step_results[$];
    t_link_result  results_due[$];
    t_directed_row directed_rows[$];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;
    int  rx_hold = 0;

    go_back_n_link_controller uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_cycles(input bit burst);
        int w;
        w = $urandom_range(0, 99);
        if (burst || w < 55)
            return 0;
        else if (w < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 50)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    // Circular half-open test: b lies in [a, c).
    function automatic bit seq_in_window(input logic [SEQ_W-1:0] a,
                                         input logic [SEQ_W-1:0] b,
                                         input logic [SEQ_W-1:0] c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

    // Append one result; the ack number reflects the receive state right now.
    task automatic push_result(input logic [KIND_W-1:0] kind, input logic [SEQ_W-1:0] seq,
                               input logic [PKT_W-1:0] packet,
                               input logic [TIMER_W-1:0] timer);
        t_link_result r;
        r.kind           = kind;
        r.seq            = seq;
        r.ack_number     = link_rx_expect - 1'b1;
        r.packet         = packet;
        r.timer_length   = timer;
        r.network_enable = 1'b0;
        r.last           = 1'b0;
        step_results.push_back(r);
    endtask

    // Sending a data frame consumes the physical layer ready flag.
    task automatic push_data_frame(input logic [SEQ_W-1:0] s);
        link_phy_ready = 1'b0;
        push_result(KIND_SEND_DATA, s, link_slots[s], link_retx_time);
    endtask

    // Compute the results of one request and advance the mirrored state.
    task automatic predict_link_step(input t_link_req r);
        logic [SEQ_W-1:0] s;
        logic             en;
        int               i;
        step_results.delete();
        case (r.action)
            ACT_NEW_PACKET: begin
                if (link_in_flight < SEND_WINDOW) begin
                    link_slots[link_next_seq] = r.tx_packet;
                    link_in_flight = link_in_flight + 1'b1;
                    push_data_frame(link_next_seq);
                    link_next_seq = link_next_seq + 1'b1;
                end
            end
            ACT_PHY_READY: begin
                link_phy_ready = 1'b1;
            end
            ACT_FRAME_RX: begin
                if (r.rx_valid) begin
                    if (r.rx_kind == RX_KIND_DATA) begin
                        if (r.rx_seq == link_rx_expect) begin
                            push_result(KIND_DELIVER, '0, r.rx_packet, '0);
                            link_rx_expect = link_rx_expect + 1'b1;
                        end
                        link_phy_ready = 1'b0;
                        push_result(KIND_SEND_ACK, '0, '0, '0);
                    end
                    // Cumulative ack releases frames from the window base upward.
                    while (link_in_flight != '0 &&
                           seq_in_window(link_base, r.rx_ack, link_next_seq)) begin
                        link_in_flight = link_in_flight - 1'b1;
                        push_result(KIND_STOP_TIMER, link_base, '0, '0);
                        link_base = link_base + 1'b1;
                    end
                end
            end
            default: begin
                // Timeout: resend the whole window in order.
                s = link_base;
                for (i = 0; i < int'(link_in_flight); i++) begin
                    push_data_frame(s);
                    s = s + 1'b1;
                end
            end
        endcase
        if (step_results.size() == 0)
            push_result(KIND_STATUS, '0, '0, '0);
        en = (link_in_flight < SEND_WINDOW) && link_phy_ready;
        foreach (step_results[k]) begin
            step_results[k].network_enable = en;
            step_results[k].last = (k == step_results.size() - 1);
        end
    endtask

    // Directed row; a typed row expects a single status result.
    task automatic add_row(input logic [ACT_W-1:0] action, input logic [PKT_W-1:0] tx,
                           input logic valid, input logic kind, input logic [SEQ_W-1:0] seq,
                           input logic [SEQ_W-1:0] ack, input logic [PKT_W-1:0] rxp,
                           input bit typed, input logic [SEQ_W-1:0] want_ack,
                           input logic want_en);
        t_directed_row row;
        row.req.action             = action;
        row.req.tx_packet          = tx;
        row.req.rx_valid           = valid;
        row.req.rx_kind            = kind;
        row.req.rx_seq             = seq;
        row.req.rx_ack             = ack;
        row.req.rx_packet          = rxp;
        row.typed                  = typed;
        row.result.kind            = KIND_STATUS;
        row.result.seq             = '0;
        row.result.ack_number      = want_ack;
        row.result.packet          = '0;
        row.result.timer_length    = '0;
        row.result.network_enable  = want_en;
        row.result.last            = 1'b1;
        directed_rows.push_back(row);
    endtask

    // Random request shaped by the current window so acks mostly land inside it.
    function automatic t_link_req random_request();
        t_link_req r;
        int        w;
        w = $urandom_range(0, 99);
        if (w < 35)
            r.action = ACT_NEW_PACKET;
        else if (w < 50)
            r.action = ACT_PHY_READY;
        else if (w < 85)
            r.action = ACT_FRAME_RX;
        else
            r.action = ACT_TIMEOUT;
        r.tx_packet = $urandom();
        r.rx_valid  = ($urandom_range(0, 9) != 0);
        r.rx_kind   = 1'($urandom_range(0, 1));
        r.rx_seq    = ($urandom_range(0, 3) != 0) ? link_rx_expect
                                                  : SEQ_W'($urandom_range(0, 7));
        if (link_in_flight != '0 && $urandom_range(0, 3) != 0)
            r.rx_ack = link_base + SEQ_W'($urandom_range(0, int'(link_in_flight) - 1));
        else
            r.rx_ack = SEQ_W'($urandom_range(0, 7));
        r.rx_packet = $urandom();
        return r;
    endfunction

    // Present one request and wait until it is accepted.
    task automatic send_request(input t_link_req r);
        int gap;
        gap = idle_cycles(tx_burst);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, r.rx_packet, r.rx_ack, r.rx_seq, r.rx_valid, r.tx_packet};
        i_s_axis_tuser  <= {r.rx_kind, r.action};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // Stop sending and wait until every due result has come back.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_retransmit_time(input logic [TIMER_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        link_retx_time = value;
    endtask

    // Compare one accepted result with the oldest one due.
    task automatic check_result();
        t_link_result got;
        t_link_result want;
        got.kind           = o_m_axis_tuser;
        got.seq            = o_m_axis_tdata[2:0];
        got.ack_number     = o_m_axis_tdata[5:3];
        got.packet         = o_m_axis_tdata[37:6];
        got.timer_length   = o_m_axis_tdata[53:38];
        got.network_enable = o_m_axis_tdata[54];
        got.last           = o_m_axis_tlast;
        if (results_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result of kind %0d", got.kind));
            return;
        end
        want = results_due.pop_front();
        compare_field("kind", 32'(got.kind), 32'(want.kind));
        compare_field("seq", 32'(got.seq), 32'(want.seq));
        compare_field("ack_number", 32'(got.ack_number), 32'(want.ack_number));
        compare_field("packet", got.packet, want.packet);
        compare_field("timer_length", 32'(got.timer_length), 32'(want.timer_length));
        compare_field("network_enable", 32'(got.network_enable), 32'(want.network_enable));
        compare_field("last", 32'(got.last), 32'(want.last));
    endtask

    // Result side: check on each transfer, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                check_result();
            if ($urandom_range(0, 299) == 0)
                rx_burst = ~rx_burst;
            if (rx_hold > 0) begin
                i_m_axis_tready <= 1'b0;
                rx_hold = rx_hold - 1;
            end else begin
                i_m_axis_tready <= 1'b1;
                rx_hold = idle_cycles(rx_burst);
            end
        end
    end

    // Request side: reset, directed table, then random phases.
    initial begin
        t_link_req                req;
        logic [TIMER_W-1:0]       phase_time;
        int                       counted;
        int                       phase;

        counted = 0;

        // Idle link after reset: everything answers with status.
        add_row(ACT_TIMEOUT, '0, 1'b0, RX_KIND_DATA, 3'd0, 3'd0, '0, 1'b1, 3'd7, 1'b0);
        add_row(ACT_FRAME_RX, 32'hFFFF_FFFF, 1'b0, RX_KIND_DATA, 3'd7, 3'd7, 32'hFFFF_FFFF,
                1'b1, 3'd7, 1'b0);
        add_row(ACT_PHY_READY, '0, 1'b0, RX_KIND_DATA, 3'd0, 3'd0, '0, 1'b1, 3'd7, 1'b1);
        add_row(ACT_FRAME_RX, '0, 1'b1, RX_KIND_ACK, 3'd0, 3'd7, '0, 1'b1, 3'd7, 1'b1);
        // Fill the window with extreme tags.
        add_row(ACT_NEW_PACKET, 32'h0000_0000, 1'b0, RX_KIND_DATA, 3'd0, 3'd0, '0, 1'b0, '0, 1'b0);
        add_row(ACT_NEW_PACKET, 32'hFFFF_FFFF, 1'b1, RX_KIND_ACK, 3'd7, 3'd7, 32'hFFFF_FFFF,
                1'b0, '0, 1'b0);
        add_row(ACT_NEW_PACKET, 32'hAAAA_AAAA, 1'b0, RX_KIND_DATA, 3'd0, 3'd0, '0, 1'b0, '0, 1'b0);
        add_row(ACT_NEW_PACKET, 32'h5555_5555, 1'b0, RX_KIND_DATA, 3'd0, 3'd0, '0, 1'b0, '0, 1'b0);
        repeat (3)
            add_row(ACT_NEW_PACKET, $urandom(), 1'b0, RX_KIND_DATA, 3'd0, 3'd0, '0, 1'b0, '0, 1'b0);
        // Full window: ready does not enable, and a new packet is refused.
        add_row(ACT_PHY_READY, '0, 1'b0, RX_KIND_DATA, 3'd0, 3'd0, '0, 1'b1, 3'd7, 1'b0);
        add_row(ACT_NEW_PACKET, $urandom(), 1'b0, RX_KIND_DATA, 3'd0, 3'd0, '0, 1'b1, 3'd7, 1'b0);
        // Timeout resends all seven frames.
        add_row(ACT_TIMEOUT, '0, 1'b0, RX_KIND_DATA, 3'd0, 3'd0, '0, 1'b0, '0, 1'b0);
        // In-order data with a piggybacked ack, then out-of-order data with an ack outside.
        add_row(ACT_FRAME_RX, '0, 1'b1, RX_KIND_DATA, 3'd0, 3'd2, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
        add_row(ACT_FRAME_RX, '0, 1'b1, RX_KIND_DATA, 3'd5, 3'd7, $urandom(), 1'b0, '0, 1'b0);
        // Pure ack empties the window.
        add_row(ACT_FRAME_RX, '0, 1'b1, RX_KIND_ACK, 3'd0, 3'd6, '0, 1'b0, '0, 1'b0);
        add_row(ACT_PHY_READY, '0, 1'b0, RX_KIND_DATA, 3'd0, 3'd0, '0, 1'b1, 3'd0, 1'b1);
        // Refill across the wrap, then one frame that releases all seven.
        repeat (7)
            add_row(ACT_NEW_PACKET, $urandom(), 1'b0, RX_KIND_DATA, 3'd0, 3'd0, '0, 1'b0, '0, 1'b0);
        add_row(ACT_FRAME_RX, '0, 1'b1, RX_KIND_DATA, 3'd1, 3'd5, 32'h0000_0000, 1'b0, '0, 1'b0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part runs with the timer register at its reset value.
        foreach (directed_rows[n]) begin
            send_request(directed_rows[n].req);
            predict_link_step(directed_rows[n].req);
            if (directed_rows[n].typed)
                results_due.push_back(directed_rows[n].result);
            else
                foreach (step_results[k]) results_due.push_back(step_results[k]);
        end

        // Random phases, each with its own timer setting written while idle.
        for (phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case (phase)
                0:       phase_time = 16'hFFFF;
                1:       phase_time = 16'h0000;
                default: phase_time = TIMER_W'($urandom_range(1, 65534));
            endcase
            write_retransmit_time(phase_time);
            while (counted < (phase + 1) * RANDOM_ITEMS / PHASES) begin
                if ($urandom_range(0, 59) == 0)
                    drain_results();
                if ($urandom_range(0, 39) == 0)
                    tx_burst = ~tx_burst;
                req = random_request();
                send_request(req);
                predict_link_step(req);
                foreach (step_results[k]) results_due.push_back(step_results[k]);
                if (!(req.action == ACT_FRAME_RX && !req.rx_valid))
                    counted++;
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && results_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/gbn_pkg.sv
hdl/gbn_slot_ram.sv
hdl/go_back_n_link_controller.sv
sim/tb_go_back_n_link_controller.sv
